### hdl/ucer_pkg.sv
// Types and codes shared by the endpoint-zero responder modules.
package ucer_pkg;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_FIELDS_W = 75;
  localparam int OUT_TDATA_W = 40;

  // Bus event codes carried on in_tuser.
  localparam logic [2:0] OP_BUS_RESET  = 3'd0;
  localparam logic [2:0] OP_RESUME     = 3'd1;
  localparam logic [2:0] OP_SUSPEND    = 3'd2;
  localparam logic [2:0] OP_DISCONNECT = 3'd3;
  localparam logic [2:0] OP_EP0_IRQ    = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEVICE_DESC_LEN = 3'd0;
  localparam logic [2:0] REG_CONFIG_DESC_LEN = 3'd1;
  localparam logic [2:0] REG_LANGID_LEN      = 3'd2;
  localparam logic [2:0] REG_VENDOR_STR_LEN  = 3'd3;
  localparam logic [2:0] REG_PRODUCT_STR_LEN = 3'd4;
  localparam logic [2:0] REG_IFACE_STR_LEN   = 3'd5;
  localparam logic [2:0] REG_SERIAL_STR_LEN  = 3'd6;

  // Request type field (bmRequestType bits 6..5).
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;

  // Request codes.
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] REQ_GET_MAX_LUN       = 8'hFE;

  // Descriptor types and special string indexes.
  localparam logic [7:0] DT_DEVICE     = 8'h01;
  localparam logic [7:0] DT_CONFIG     = 8'h02;
  localparam logic [7:0] DT_STRING     = 8'h03;
  localparam logic [7:0] STR_LANGID    = 8'h00;
  localparam logic [7:0] STR_VENDOR    = 8'h01;
  localparam logic [7:0] STR_PRODUCT   = 8'h02;
  localparam logic [7:0] STR_VENDOR_B  = 8'h03;
  localparam logic [7:0] STR_INTERFACE = 8'h04;
  localparam logic [7:0] STR_VENDOR_OS = 8'hEE;

  localparam logic [6:0] SETUP_BYTES = 7'd8;

  // Reply sources.
  localparam logic [2:0] SRC_DEVICE    = 3'd0;
  localparam logic [2:0] SRC_CONFIG    = 3'd1;
  localparam logic [2:0] SRC_LANGID    = 3'd2;
  localparam logic [2:0] SRC_VENDOR    = 3'd3;
  localparam logic [2:0] SRC_PRODUCT   = 3'd4;
  localparam logic [2:0] SRC_INTERFACE = 3'd5;
  localparam logic [2:0] SRC_SERIAL    = 3'd6;
  localparam logic [2:0] SRC_ZERO      = 3'd7;

  // Speed codes.
  localparam logic [1:0] SPEED_UNKNOWN = 2'd0;
  localparam logic [1:0] SPEED_FULL    = 2'd1;
  localparam logic [1:0] SPEED_HIGH    = 2'd2;

  // Acknowledge flag bits.
  localparam logic [2:0] ACK_STALL_CLR = 3'b001;
  localparam logic [2:0] ACK_SETUP_END = 3'b010;
  localparam logic [2:0] ACK_REJECT    = 3'b100;

  // Endpoint actions.
  localparam logic [1:0] EPA_NONE      = 2'd0;
  localparam logic [1:0] EPA_CONFIGURE = 2'd1;
  localparam logic [1:0] EPA_RESET_OUT = 2'd2;
  localparam logic [1:0] EPA_RESET_IN  = 2'd3;

  localparam logic [1:0] BULK_EP = 2'd1;

  typedef struct packed {
    logic [7:0] device_desc_len;
    logic [9:0] config_desc_len;
    logic [7:0] langid_len;
    logic [7:0] vendor_str_len;
    logic [7:0] product_str_len;
    logic [7:0] interface_str_len;
    logic [7:0] serial_str_len;
  } cfg_t;

  typedef struct packed {
    logic       link_up;
    logic [1:0] negotiated_speed;
    logic       in_data_phase;
    logic       address_pending;
    logic [6:0] pending_address;
    logic [9:0] bytes_left;
    logic [2:0] reply_source;
    logic [9:0] reply_offset;
  } state_t;

  // Lowest field last, so the packed vector matches the tuser/tdata layout.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] request_length;
    logic [15:0] request_index;
    logic [15:0] request_value;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
    logic [6:0]  packet_count;
    logic        packet_ready;
    logic        setup_ended;
    logic        stall_was_sent;
    logic        high_speed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] endpoint_select;
    logic [1:0] endpoint_action;
    logic       data_end;
    logic [6:0] chunk_length;
    logic [9:0] chunk_offset;
    logic [2:0] chunk_source;
    logic       chunk_valid;
    logic [2:0] ack_flags;
    logic [6:0] function_address;
    logic       address_apply;
    logic [1:0] speed;
    logic       connected;
  } out_item_t;

endpackage

### hdl/ucer_core.sv
// Next-state and result logic for one bus event or endpoint-zero interrupt.
module ucer_core
  import ucer_pkg::*;
#(
  parameter int EP0_FIFO_BYTES = 64
) (
  input  cfg_t      cfg,
  input  state_t    state,
  input  in_item_t  item,
  output state_t    state_nxt,
  output out_item_t res
);

  localparam logic [9:0] FIFO_LEN = 10'(EP0_FIFO_BYTES);

  logic [9:0] desc_len;
  logic [2:0] desc_src;
  logic [9:0] clip_len;
  logic [6:0] first_len;
  logic [9:0] rem_len;
  logic [6:0] cont_len;
  logic [9:0] cont_left;
  logic [1:0] rtype;

  // Descriptor lookup and clipping to wLength and the FIFO size.
  always_comb begin
    desc_len = '0;
    desc_src = SRC_DEVICE;
    case (item.request_value[15:8])
      DT_DEVICE: begin
        desc_len = {2'b00, cfg.device_desc_len};
        desc_src = SRC_DEVICE;
      end
      DT_CONFIG: begin
        desc_len = cfg.config_desc_len;
        desc_src = SRC_CONFIG;
      end
      DT_STRING: begin
        case (item.request_value[7:0]) inside
          STR_LANGID: begin
            desc_len = {2'b00, cfg.langid_len};
            desc_src = SRC_LANGID;
          end
          STR_VENDOR, STR_VENDOR_B, STR_VENDOR_OS: begin
            desc_len = {2'b00, cfg.vendor_str_len};
            desc_src = SRC_VENDOR;
          end
          STR_PRODUCT: begin
            desc_len = {2'b00, cfg.product_str_len};
            desc_src = SRC_PRODUCT;
          end
          STR_INTERFACE: begin
            desc_len = {2'b00, cfg.interface_str_len};
            desc_src = SRC_INTERFACE;
          end
          default: begin
            desc_len = {2'b00, cfg.serial_str_len};
            desc_src = SRC_SERIAL;
          end
        endcase
      end
      default: begin
        desc_len = '0;
        desc_src = SRC_DEVICE;
      end
    endcase
    clip_len  = ({6'b0, desc_len} > item.request_length) ? item.request_length[9:0]
                                                          : desc_len;
    first_len = (clip_len > FIFO_LEN) ? FIFO_LEN[6:0] : clip_len[6:0];
    rem_len   = clip_len - {3'b000, first_len};
    cont_len  = (state.bytes_left > FIFO_LEN) ? FIFO_LEN[6:0] : state.bytes_left[6:0];
    cont_left = state.bytes_left - {3'b000, cont_len};
    rtype     = item.request_type[6:5];
  end

  always_comb begin
    state_nxt = state;
    res       = '0;
    case (item.opcode) inside
      OP_BUS_RESET: begin
        state_nxt.link_up       = 1'b1;
        state_nxt.in_data_phase = 1'b0;
        res.address_apply       = 1'b1;
      end
      OP_RESUME: begin
        state_nxt.link_up       = 1'b1;
        state_nxt.in_data_phase = 1'b0;
      end
      OP_SUSPEND, OP_DISCONNECT: begin
        state_nxt.link_up       = 1'b0;
        state_nxt.in_data_phase = 1'b0;
      end
      OP_EP0_IRQ: begin
        if (state.negotiated_speed == SPEED_UNKNOWN) begin
          state_nxt.negotiated_speed = item.high_speed ? SPEED_HIGH : SPEED_FULL;
        end
        if (state.address_pending) begin
          res.address_apply         = 1'b1;
          res.function_address      = state.pending_address;
          state_nxt.address_pending = 1'b0;
        end
        if (item.stall_was_sent) begin
          // A sent stall only gets acknowledged; the rest of CSR0 is ignored.
          res.ack_flags           = ACK_STALL_CLR;
          state_nxt.in_data_phase = 1'b0;
        end else begin
          if (item.setup_ended) begin
            res.ack_flags           = ACK_SETUP_END;
            state_nxt.in_data_phase = 1'b0;
          end
          if (!state_nxt.in_data_phase) begin
            if (item.packet_ready) begin
              if (item.packet_count == SETUP_BYTES) begin
                if (rtype == RT_STANDARD) begin
                  case (item.request_code)
                    REQ_GET_DESCRIPTOR: begin
                      if (desc_len != '0) begin
                        res.chunk_valid  = 1'b1;
                        res.chunk_source = desc_src;
                        res.chunk_length = first_len;
                        if (rem_len != '0) begin
                          state_nxt.bytes_left    = rem_len;
                          state_nxt.reply_source  = desc_src;
                          state_nxt.reply_offset  = {3'b000, first_len};
                          state_nxt.in_data_phase = 1'b1;
                        end
                      end
                    end
                    REQ_SET_ADDRESS: begin
                      state_nxt.address_pending = 1'b1;
                      state_nxt.pending_address = item.request_value[6:0];
                    end
                    REQ_SET_CONFIGURATION: begin
                      res.endpoint_action = EPA_CONFIGURE;
                      res.endpoint_select = BULK_EP;
                      res.chunk_valid     = 1'b1;
                      res.chunk_source    = SRC_ZERO;
                    end
                    REQ_CLEAR_FEATURE: begin
                      res.endpoint_action = item.request_index[7] ? EPA_RESET_IN
                                                                  : EPA_RESET_OUT;
                      res.endpoint_select = item.request_index[1:0];
                    end
                    default: begin
                      res.endpoint_action = EPA_NONE;
                    end
                  endcase
                end else if (rtype == RT_CLASS) begin
                  if (item.request_code == REQ_GET_MAX_LUN &&
                      item.request_length != '0) begin
                    res.chunk_valid  = 1'b1;
                    res.chunk_source = SRC_ZERO;
                    res.chunk_length = 7'd1;
                  end
                end
                // A reply longer than one chunk, after clipping to wLength, keeps the data stage open.
                if (!state_nxt.in_data_phase) begin
                  res.data_end = 1'b1;
                end
              end else begin
                res.ack_flags = res.ack_flags | ACK_REJECT;
              end
            end
          end else if (state.bytes_left != '0) begin
            res.chunk_valid      = 1'b1;
            res.chunk_source     = state.reply_source;
            res.chunk_offset     = state.reply_offset;
            res.chunk_length     = cont_len;
            state_nxt.bytes_left = cont_left;
            if (cont_left != '0) begin
              state_nxt.reply_offset = state.reply_offset + {3'b000, cont_len};
            end else begin
              res.data_end            = 1'b1;
              state_nxt.in_data_phase = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
    res.connected = state_nxt.link_up;
    res.speed     = state_nxt.negotiated_speed;
  end

endmodule

### hdl/usb_control_endpoint_responder.sv
// USB device endpoint-zero responder: the top level with its stream registers.
//
// Input beats carry one bus event each: in_tuser holds the event code (bus
// reset, resume, suspend, disconnect, endpoint-zero interrupt) and in_tdata
// the CSR0 flags and the decoded setup packet. Every input beat yields exactly
// one output beat on out_tdata: link and speed status, a deferred address to
// load, CSR0 acknowledge flags, the descriptor chunk to transmit (source,
// offset, length), data-stage completion and an endpoint action.
// Descriptor lengths are set through the cfg_ write port, by the user only while
// no beat is in flight, which the block does not enforce; a write takes effect at the next clock edge.
// A beat passes through the input register, then is decoded into the output
// register, where the control state is updated as well. One beat per cycle
// is sustained while out_tready stays high; the state update in the decode
// step is what sets that figure.
// When out_tready is low the output register holds its beat, the input
// register can still take one more beat, and in_tready then drops.
// Reset (rst_n low at a clock edge) empties both registers, clears the link,
// speed and reply state and restores the default descriptor lengths.
module usb_control_endpoint_responder
  import ucer_pkg::*;
#(
  parameter int EP0_FIFO_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [9:0]             cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // high_speed, stall_was_sent, setup_ended, packet_ready, packet_count,
  // request_type, request_code, request_value, request_index, request_length
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // connected, speed, address_apply, function_address, ack_flags, chunk_valid,
  // chunk_source, chunk_offset, chunk_length, data_end, endpoint_action,
  // endpoint_select
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t      cfg_r;
  state_t    state_r;
  state_t    state_nxt;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  out_item_t res;
  logic      out_valid_r;
  logic      advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_desc_len   <= 8'd18;
      cfg_r.config_desc_len   <= 10'd32;
      cfg_r.langid_len        <= 8'd4;
      cfg_r.vendor_str_len    <= '0;
      cfg_r.product_str_len   <= '0;
      cfg_r.interface_str_len <= '0;
      cfg_r.serial_str_len    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_DESC_LEN: cfg_r.device_desc_len   <= cfg_wdata[7:0];
        REG_CONFIG_DESC_LEN: cfg_r.config_desc_len   <= cfg_wdata;
        REG_LANGID_LEN:      cfg_r.langid_len        <= cfg_wdata[7:0];
        REG_VENDOR_STR_LEN:  cfg_r.vendor_str_len    <= cfg_wdata[7:0];
        REG_PRODUCT_STR_LEN: cfg_r.product_str_len   <= cfg_wdata[7:0];
        REG_IFACE_STR_LEN:   cfg_r.interface_str_len <= cfg_wdata[7:0];
        REG_SERIAL_STR_LEN:  cfg_r.serial_str_len    <= cfg_wdata[7:0];
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_item_r <= {in_tuser, in_tdata[IN_FIELDS_W-1:0]};
    end
  end

  ucer_core #(
    .EP0_FIFO_BYTES(EP0_FIFO_BYTES)
  ) u_core (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  // A reply phase is open only while bytes remain to be sent.
  a_phase_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.in_data_phase |-> state_r.bytes_left != '0)
    else $error("data phase open with no bytes left");

  a_chunk_fits_fifo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> {3'b000, out_item_r.chunk_length} <= 10'(EP0_FIFO_BYTES))
    else $error("chunk longer than the endpoint FIFO");

  a_no_chunk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.chunk_valid) |->
      (out_item_r.chunk_length == '0 && out_item_r.chunk_offset == '0 &&
       out_item_r.chunk_source == '0))
    else $error("chunk fields set without a chunk");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the output register is empty");

endmodule
